[design/swda_pkg.sv]
// shared constants, codes and types of the sliding window drift auditor
`timescale 1ns / 1ps
package swda_pkg;

   localparam int MAX_WINDOW   = 16;
   localparam int SLOT_W       = $clog2(MAX_WINDOW);
   localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
   localparam int VECTOR_BYTES = 32;
   localparam int VWORDS       = (VECTOR_BYTES + 7) / 8;
   localparam int VWORD_W      = (VWORDS > 1) ? $clog2(VWORDS) : 1;
   localparam int NMET         = 6;
   localparam int MET_DEPTH    = MAX_WINDOW * NMET;
   localparam int MET_ADDR_W   = $clog2(MET_DEPTH);
   localparam int VEC_ADDR_W   = SLOT_W + VWORD_W;
   localparam int NUM_RESULTS  = 14;
   localparam int SUM_W        = 32 + CNT_W;
   localparam int DRIFT_W      = 33 + SLOT_W + 2;
   localparam int SSUM_W       = $clog2(VECTOR_BYTES * 65025 + 1);
   localparam int ASUM_W       = 32;
   localparam int ONE_Q16      = 65536;

   localparam logic CMD_STAGE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [1:0] CSR_DRIFT_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_ANCHOR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd2;

   localparam logic [3:0] QTY_DRIFT        = 4'd6;
   localparam logic [3:0] QTY_STABILITY    = 4'd7;
   localparam logic [3:0] QTY_PEAK         = 4'd8;
   localparam logic [3:0] QTY_COV_EVO      = 4'd9;
   localparam logic [3:0] QTY_SPEC_ALIGN   = 4'd10;
   localparam logic [3:0] QTY_ANCHOR_DRIFT = 4'd11;
   localparam logic [3:0] QTY_REPLAY_STAB  = 4'd12;
   localparam logic [3:0] QTY_COHERENCE    = 4'd13;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MET_RD,
      ST_MET_ACC,
      ST_DST_RD,
      ST_DST_LD,
      ST_DST_BYTE,
      ST_SQRT,
      ST_DIV_LD,
      ST_DIV,
      ST_FIN,
      ST_EMIT,
      ST_PUSH_PREP,
      ST_PUSH_WR
   } state_type;

endpackage

[design/sliding_window_drift_auditor_top.sv]
// sliding window drift auditor: window store, sequencer and shared divide / square root unit
//
// req_ channel: command 0 stages one 64-bit vector word; command 1 evaluates
// the current epoch against the stored window and returns fourteen rsp_ transactions,
// quantity 0 to 13, last_of_run on the last. The block takes one req_ transaction at a
// time and is not ready again until all results are delivered and the optional push ends.
// Evaluation walks the metrics of the stored entries and the current epoch, computes the
// vector distances (two per pair, each a run of byte steps and then square root steps),
// runs eight divisions in the shared unit, then emits the results and does the optional push.
// An empty window skips the walk, distances and divisions.
// Result values are held in registers; when rsp_ready is low the current result waits
// with its payload stable and the sequencer stands still.
// Reset (synchronous, active high) empties the window, clears the staged vectors and
// loads the csr_ registers with 1.0, 1.0 and a window length of 16; no clearing pass is
// needed. csr_ writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
module sliding_window_drift_auditor_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [2:0]          req_word_slot,
   input  logic [63:0]         req_word_data,
   input  logic signed [31:0]  req_covariance_error,
   input  logic signed [31:0]  req_spectral_shift,
   input  logic signed [31:0]  req_memory_delta,
   input  logic signed [31:0]  req_context_leak,
   input  logic signed [31:0]  req_null_match_rate,
   input  logic signed [31:0]  req_auc_delta,
   input  logic                req_push_after,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_quantity,
   output logic signed [63:0]  rsp_value,
   output logic                rsp_last_of_run,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_write_data
);

   swda_pkg::state_type state_ff, state_in;

   logic [31:0] drift_limit_ff;
   logic [31:0] anchor_limit_ff;
   logic [4:0]  window_length_ff;

   logic [swda_pkg::CNT_W-1:0]  cnt_ff;
   logic [swda_pkg::SLOT_W-1:0] oldest_ff;
   logic [63:0] stg_anc_ff [swda_pkg::VWORDS];
   logic [63:0] stg_rep_ff [swda_pkg::VWORDS];

   logic signed [31:0] cur_ff [swda_pkg::NMET];
   logic               push_ff;

   logic [swda_pkg::CNT_W-1:0] i_ff;
   logic [2:0]                 j_ff;
   logic signed [swda_pkg::SUM_W-1:0] sum_ff [swda_pkg::NMET];
   logic [swda_pkg::DRIFT_W-1:0] drift_ff;
   logic signed [31:0] peak_ff;
   logic signed [31:0] prev_cov_ff, prev_spec_ff, first_cov_ff, first_spec_ff;

   logic [swda_pkg::SLOT_W-1:0]  pair_ff;
   logic                         vk_ff;
   logic [swda_pkg::VWORD_W-1:0] word_ff;
   logic [2:0]                   byte_ff;
   logic [swda_pkg::SSUM_W-1:0]  ssum_ff;
   logic [63:0]                  wa_ff, wb_ff;
   logic [swda_pkg::ASUM_W-1:0]  asum_ff;
   logic [31:0]                  rmax_ff, adrift_ff;

   logic [63:0] ua_ff, ub_ff, uc_ff;
   logic [5:0]  it_ff;

   logic signed [63:0] res_ff [swda_pkg::NUM_RESULTS];
   logic [3:0]         qty_ff;

   logic [31:0] metric_mem [swda_pkg::MET_DEPTH];
   logic [63:0] anchor_mem [swda_pkg::MAX_WINDOW * swda_pkg::VWORDS];
   logic [63:0] replay_mem [swda_pkg::MAX_WINDOW * swda_pkg::VWORDS];
   logic signed [31:0] met_rd_ff;
   logic [63:0] anc_a_ff, anc_b_ff, rep_a_ff, rep_b_ff;

   // addressing
   logic [swda_pkg::SLOT_W-1:0]     met_slot, q_slot, p_slot, wr_slot;
   logic [swda_pkg::MET_ADDR_W-1:0] met_raddr, met_waddr;
   logic [swda_pkg::VEC_ADDR_W-1:0] vaddr_a, vaddr_b, vaddr_w;
   logic                            met_we, vec_we;

   assign met_slot  = oldest_ff + i_ff[swda_pkg::SLOT_W-1:0];
   assign q_slot    = oldest_ff + pair_ff;
   assign p_slot    = (pair_ff == '0) ? oldest_ff + cnt_ff[swda_pkg::SLOT_W-1:0]
                      - swda_pkg::SLOT_W'(1) : oldest_ff + pair_ff - swda_pkg::SLOT_W'(1);
   assign wr_slot   = oldest_ff + cnt_ff[swda_pkg::SLOT_W-1:0];
   assign met_raddr = swda_pkg::MET_ADDR_W'(met_slot) * swda_pkg::MET_ADDR_W'(swda_pkg::NMET)
                      + swda_pkg::MET_ADDR_W'(j_ff);
   assign met_waddr = swda_pkg::MET_ADDR_W'(wr_slot) * swda_pkg::MET_ADDR_W'(swda_pkg::NMET)
                      + swda_pkg::MET_ADDR_W'(j_ff);
   assign vaddr_a   = {q_slot, word_ff};
   assign vaddr_b   = {p_slot, word_ff};
   assign vaddr_w   = {wr_slot, j_ff[swda_pkg::VWORD_W-1:0]};
   assign met_we    = (state_ff == swda_pkg::ST_PUSH_WR);
   assign vec_we    = met_we && (j_ff < 3'(swda_pkg::VWORDS));

   always_ff @(posedge clock) begin
      if (met_we) begin
         metric_mem[met_waddr] <= cur_ff[j_ff];
      end
      met_rd_ff <= metric_mem[met_raddr];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         anchor_mem[vaddr_w] <= stg_anc_ff[j_ff[swda_pkg::VWORD_W-1:0]];
         replay_mem[vaddr_w] <= stg_rep_ff[j_ff[swda_pkg::VWORD_W-1:0]];
      end
      anc_a_ff <= anchor_mem[vaddr_a];
      anc_b_ff <= anchor_mem[vaddr_b];
      rep_a_ff <= replay_mem[vaddr_a];
      rep_b_ff <= replay_mem[vaddr_b];
   end

   // metric walk datapath
   logic signed [31:0] mx;
   logic signed [32:0] mdiff;
   logic [32:0]        mabs;

   always_comb begin
      mx    = (i_ff == cnt_ff) ? cur_ff[j_ff] : met_rd_ff;
      mdiff = 33'(mx) - 33'((j_ff == 3'd0) ? prev_cov_ff : prev_spec_ff);
      mabs  = mdiff[32] ? 33'(-mdiff) : 33'(mdiff);
   end

   // byte distance step
   logic signed [8:0]           bd;
   logic signed [17:0]          bsq;
   logic [swda_pkg::SSUM_W-1:0] ssum_nx;

   always_comb begin
      bd      = $signed({1'b0, wa_ff[7:0]}) - $signed({1'b0, wb_ff[7:0]});
      bsq     = bd * bd;
      ssum_nx = ssum_ff + swda_pkg::SSUM_W'(bsq[15:0]);
   end

   // shared divide / square root step
   logic [63:0] u_lhs, u_rhs, u_diff, ua_step, ub_step, uc_step;
   logic        u_ge;

   always_comb begin
      if (state_ff == swda_pkg::ST_SQRT) begin
         u_lhs = ua_ff;
         u_rhs = ub_ff + uc_ff;
      end else begin
         u_lhs = {ua_ff[62:0], ub_ff[63]};
         u_rhs = uc_ff;
      end
      u_ge   = (u_lhs >= u_rhs);
      u_diff = u_lhs - u_rhs;
      if (state_ff == swda_pkg::ST_SQRT) begin
         ua_step = u_ge ? u_diff : ua_ff;
         ub_step = u_ge ? (ub_ff >> 1) + uc_ff : ub_ff >> 1;
         uc_step = uc_ff >> 2;
      end else begin
         ua_step = u_ge ? u_diff : u_lhs;
         ub_step = {ub_ff[62:0], u_ge};
         uc_step = uc_ff;
      end
   end

   // division operands
   logic                             div_neg;
   logic [swda_pkg::SUM_W-1:0]       div_mag;
   logic [63:0]                      div_dvd, div_dvs, div_q, ratio_res;
   logic [swda_pkg::CNT_W-1:0]       eff_len;
   logic [32:0]                      cev_abs;
   logic signed [32:0]               cev, sal;

   always_comb begin
      div_neg = 1'b0;
      div_mag = '0;
      div_dvd = '0;
      div_dvs = 64'(swda_pkg::ONE_Q16);
      if (j_ff < 3'(swda_pkg::NMET)) begin
         div_neg = sum_ff[j_ff][swda_pkg::SUM_W-1];
         div_mag = div_neg ? swda_pkg::SUM_W'(-sum_ff[j_ff]) : swda_pkg::SUM_W'(sum_ff[j_ff]);
         div_dvd = 64'(div_mag);
         div_dvs = 64'(cnt_ff) + 64'd1;
      end else if (j_ff == 3'(swda_pkg::NMET)) begin
         div_dvd = 64'({drift_ff, 16'd0});
         if (drift_limit_ff != '0) begin
            div_dvs = 64'(drift_limit_ff);
         end
      end else begin
         div_dvd = 64'({asum_ff, 16'd0});
         if (anchor_limit_ff != '0) begin
            div_dvs = 64'(anchor_limit_ff);
         end
      end
      div_q     = ub_step;
      ratio_res = (div_q >= 64'(swda_pkg::ONE_Q16)) ? 64'd0 : 64'(swda_pkg::ONE_Q16) - div_q;
      cev       = 33'(cur_ff[0]) - 33'(first_cov_ff);
      sal       = 33'(cur_ff[1]) - 33'(first_spec_ff);
      cev_abs   = sal[32] ? 33'(-sal) : 33'(sal);
      if (window_length_ff == '0) begin
         eff_len = swda_pkg::CNT_W'(1);
      end else if (window_length_ff > 5'(swda_pkg::MAX_WINDOW)) begin
         eff_len = swda_pkg::CNT_W'(swda_pkg::MAX_WINDOW);
      end else begin
         eff_len = swda_pkg::CNT_W'(window_length_ff);
      end
   end

   logic last_byte, last_word, last_pair, req_fire;

   assign last_byte = (byte_ff == 3'd7);
   assign last_word = (word_ff == swda_pkg::VWORD_W'(swda_pkg::VWORDS - 1));
   assign last_pair = ({1'b0, pair_ff} == cnt_ff - swda_pkg::CNT_W'(1));
   assign req_fire  = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swda_pkg::ST_IDLE: begin
            if (req_fire && req_command == swda_pkg::CMD_EVAL) begin
               state_in = (cnt_ff == '0) ? swda_pkg::ST_CLEAR : swda_pkg::ST_MET_RD;
            end
         end
         swda_pkg::ST_CLEAR:   state_in = swda_pkg::ST_EMIT;
         swda_pkg::ST_MET_RD:  state_in = swda_pkg::ST_MET_ACC;
         swda_pkg::ST_MET_ACC: begin
            if (j_ff == 3'(swda_pkg::NMET - 1) && i_ff == cnt_ff) begin
               state_in = swda_pkg::ST_DST_RD;
            end else begin
               state_in = swda_pkg::ST_MET_RD;
            end
         end
         swda_pkg::ST_DST_RD:  state_in = swda_pkg::ST_DST_LD;
         swda_pkg::ST_DST_LD:  state_in = swda_pkg::ST_DST_BYTE;
         swda_pkg::ST_DST_BYTE: begin
            if (last_byte) begin
               state_in = last_word ? swda_pkg::ST_SQRT : swda_pkg::ST_DST_RD;
            end
         end
         swda_pkg::ST_SQRT: begin
            if (it_ff == 6'd31) begin
               state_in = (vk_ff && last_pair) ? swda_pkg::ST_DIV_LD : swda_pkg::ST_DST_RD;
            end
         end
         swda_pkg::ST_DIV_LD:  state_in = swda_pkg::ST_DIV;
         swda_pkg::ST_DIV: begin
            if (it_ff == 6'd63) begin
               state_in = (j_ff == 3'd7) ? swda_pkg::ST_FIN : swda_pkg::ST_DIV_LD;
            end
         end
         swda_pkg::ST_FIN:     state_in = swda_pkg::ST_EMIT;
         swda_pkg::ST_EMIT: begin
            if (rsp_ready && qty_ff == swda_pkg::QTY_COHERENCE) begin
               state_in = push_ff ? swda_pkg::ST_PUSH_PREP : swda_pkg::ST_IDLE;
            end
         end
         swda_pkg::ST_PUSH_PREP: state_in = swda_pkg::ST_PUSH_WR;
         swda_pkg::ST_PUSH_WR: begin
            if (j_ff == 3'(swda_pkg::NMET - 1)) begin
               state_in = swda_pkg::ST_IDLE;
            end
         end
         default: state_in = swda_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready       = (state_ff == swda_pkg::ST_IDLE);
      rsp_valid       = (state_ff == swda_pkg::ST_EMIT);
      rsp_quantity    = qty_ff;
      rsp_value       = res_ff[qty_ff];
      rsp_last_of_run = (qty_ff == swda_pkg::QTY_COHERENCE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= swda_pkg::ST_IDLE;
         drift_limit_ff   <= 32'(swda_pkg::ONE_Q16);
         anchor_limit_ff  <= 32'(swda_pkg::ONE_Q16);
         window_length_ff <= 5'd16;
         cnt_ff           <= '0;
         oldest_ff        <= '0;
         for (int k = 0; k < swda_pkg::VWORDS; k++) begin
            stg_anc_ff[k] <= '0;
            stg_rep_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               swda_pkg::CSR_DRIFT_LIMIT:   drift_limit_ff   <= csr_write_data;
               swda_pkg::CSR_ANCHOR_LIMIT:  anchor_limit_ff  <= csr_write_data;
               swda_pkg::CSR_WINDOW_LENGTH: window_length_ff <= csr_write_data[4:0];
               default: ;
            endcase
         end
         case (state_ff)
            swda_pkg::ST_IDLE: begin
               if (req_fire) begin
                  if (req_command == swda_pkg::CMD_STAGE) begin
                     if (32'(req_word_slot[1:0]) < 32'(swda_pkg::VWORDS)) begin
                        if (!req_word_slot[2]) begin
                           stg_anc_ff[req_word_slot[swda_pkg::VWORD_W-1:0]] <= req_word_data;
                        end else begin
                           stg_rep_ff[req_word_slot[swda_pkg::VWORD_W-1:0]] <= req_word_data;
                        end
                     end
                  end else begin
                     cur_ff[0] <= req_covariance_error;
                     cur_ff[1] <= req_spectral_shift;
                     cur_ff[2] <= req_memory_delta;
                     cur_ff[3] <= req_context_leak;
                     cur_ff[4] <= req_null_match_rate;
                     cur_ff[5] <= req_auc_delta;
                     push_ff   <= req_push_after;
                     qty_ff    <= '0;
                     i_ff      <= '0;
                     j_ff      <= '0;
                     drift_ff  <= '0;
                     peak_ff   <= '0;
                     for (int k = 0; k < swda_pkg::NMET; k++) begin
                        sum_ff[k] <= '0;
                     end
                  end
               end
            end
            swda_pkg::ST_CLEAR: begin
               for (int k = 0; k < swda_pkg::NUM_RESULTS; k++) begin
                  if (4'(k) == swda_pkg::QTY_STABILITY || 4'(k) == swda_pkg::QTY_COHERENCE) begin
                     res_ff[k] <= 64'(swda_pkg::ONE_Q16);
                  end else begin
                     res_ff[k] <= '0;
                  end
               end
            end
            swda_pkg::ST_MET_ACC: begin
               sum_ff[j_ff] <= sum_ff[j_ff] + swda_pkg::SUM_W'(mx);
               if (j_ff == 3'd0 || j_ff == 3'd1) begin
                  if (i_ff != '0) begin
                     drift_ff <= drift_ff + swda_pkg::DRIFT_W'(mabs);
                  end
               end
               if (j_ff == 3'd0) begin
                  prev_cov_ff <= mx;
                  if (i_ff == '0) begin
                     first_cov_ff <= mx;
                  end
               end
               if (j_ff == 3'd1) begin
                  prev_spec_ff <= mx;
                  if (i_ff == '0) begin
                     first_spec_ff <= mx;
                  end
               end
               if (j_ff == 3'd3 && mx > peak_ff) begin
                  peak_ff <= mx;
               end
               if (j_ff == 3'(swda_pkg::NMET - 1)) begin
                  j_ff <= '0;
                  i_ff <= i_ff + swda_pkg::CNT_W'(1);
               end else begin
                  j_ff <= j_ff + 3'd1;
               end
               pair_ff   <= '0;
               vk_ff     <= 1'b0;
               word_ff   <= '0;
               ssum_ff   <= '0;
               asum_ff   <= '0;
               rmax_ff   <= '0;
               adrift_ff <= '0;
            end
            swda_pkg::ST_DST_LD: begin
               if (pair_ff == '0) begin
                  wa_ff <= vk_ff ? stg_rep_ff[word_ff] : stg_anc_ff[word_ff];
               end else begin
                  wa_ff <= vk_ff ? rep_a_ff : anc_a_ff;
               end
               wb_ff   <= vk_ff ? rep_b_ff : anc_b_ff;
               byte_ff <= '0;
            end
            swda_pkg::ST_DST_BYTE: begin
               wa_ff   <= wa_ff >> 8;
               wb_ff   <= wb_ff >> 8;
               ssum_ff <= ssum_nx;
               byte_ff <= byte_ff + 3'd1;
               if (last_byte) begin
                  if (last_word) begin
                     ua_ff <= 64'({ssum_nx, 32'd0});
                     ub_ff <= '0;
                     uc_ff <= 64'h4000_0000_0000_0000;
                     it_ff <= '0;
                  end else begin
                     word_ff <= word_ff + swda_pkg::VWORD_W'(1);
                  end
               end
            end
            swda_pkg::ST_SQRT: begin
               ua_ff <= ua_step;
               ub_ff <= ub_step;
               uc_ff <= uc_step;
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'd31) begin
                  ssum_ff <= '0;
                  word_ff <= '0;
                  if (!vk_ff) begin
                     asum_ff <= asum_ff + swda_pkg::ASUM_W'(ub_step[31:0]);
                     if (pair_ff == '0) begin
                        adrift_ff <= ub_step[31:0];
                     end
                     vk_ff <= 1'b1;
                  end else begin
                     if (pair_ff == '0 || ub_step[31:0] > rmax_ff) begin
                        rmax_ff <= ub_step[31:0];
                     end
                     vk_ff   <= 1'b0;
                     pair_ff <= pair_ff + swda_pkg::SLOT_W'(1);
                     j_ff    <= '0;
                  end
               end
            end
            swda_pkg::ST_DIV_LD: begin
               ua_ff <= '0;
               ub_ff <= div_dvd;
               uc_ff <= div_dvs;
               it_ff <= '0;
            end
            swda_pkg::ST_DIV: begin
               ua_ff <= ua_step;
               ub_ff <= ub_step;
               uc_ff <= uc_step;
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'd63) begin
                  if (j_ff < 3'(swda_pkg::NMET)) begin
                     res_ff[4'(j_ff)] <= div_neg ? -$signed(div_q) : $signed(div_q);
                  end else if (j_ff == 3'(swda_pkg::NMET)) begin
                     res_ff[swda_pkg::QTY_STABILITY] <= ratio_res;
                  end else begin
                     res_ff[swda_pkg::QTY_COHERENCE] <= ratio_res;
                  end
                  j_ff <= j_ff + 3'd1;
               end
            end
            swda_pkg::ST_FIN: begin
               res_ff[swda_pkg::QTY_DRIFT]        <= 64'(drift_ff);
               res_ff[swda_pkg::QTY_PEAK]         <= 64'(peak_ff);
               res_ff[swda_pkg::QTY_COV_EVO]      <= 64'(cev);
               res_ff[swda_pkg::QTY_SPEC_ALIGN]   <= 64'(cev_abs);
               res_ff[swda_pkg::QTY_ANCHOR_DRIFT] <= 64'(adrift_ff);
               res_ff[swda_pkg::QTY_REPLAY_STAB]  <= 64'(rmax_ff);
            end
            swda_pkg::ST_EMIT: begin
               if (rsp_ready) begin
                  qty_ff <= qty_ff + 4'd1;
               end
               j_ff <= '0;
            end
            swda_pkg::ST_PUSH_PREP: begin
               if (cnt_ff >= eff_len) begin
                  oldest_ff <= oldest_ff
                               + swda_pkg::SLOT_W'(cnt_ff - eff_len + swda_pkg::CNT_W'(1));
                  cnt_ff    <= eff_len - swda_pkg::CNT_W'(1);
               end
            end
            swda_pkg::ST_PUSH_WR: begin
               j_ff <= j_ff + 3'd1;
               if (j_ff == 3'(swda_pkg::NMET - 1)) begin
                  cnt_ff <= cnt_ff + swda_pkg::CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= swda_pkg::CNT_W'(swda_pkg::MAX_WINDOW))
      else $error("window entry count above capacity");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready for a transaction while results are pending");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run |=> !rsp_valid)
      else $error("result after the last of a run");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == swda_pkg::ST_PUSH_WR && state_in == swda_pkg::ST_IDLE
      |=> cnt_ff != '0)
      else $error("push left the window empty");

endmodule
